// ===== rtl/ccr_pkg.sv =====
// Shared types, constants and table-building functions for the contrast ratio checker.
`default_nettype none

package ccr_pkg;

  localparam int LIN_W   = 16;                    // linear channel value, Q0.16
  localparam int LUM_W   = 16;                    // relative luminance, Q0.16
  localparam int PROD_W  = 32;                    // weight times linear value
  localparam int NUM_W   = 17;                    // luminance plus offset
  localparam int FRAC_W  = 8;                     // fraction bits of the ratio
  localparam int RATIO_W = 13;                    // Q5.8 ratio
  localparam int DVD_W   = NUM_W + FRAC_W + 1;    // rounded dividend
  localparam int CMP_W   = NUM_W + 4;             // room for 9 * den
  localparam int NUM_CH  = 6;                     // three channels per color, two colors

  localparam logic [LIN_W-1:0]  W_RED      = 16'd13933;
  localparam logic [LIN_W-1:0]  W_GREEN    = 16'd46871;
  localparam logic [LIN_W-1:0]  W_BLUE     = 16'd4732;
  localparam logic [NUM_W-1:0]  LUM_OFFSET = 17'd3277;
  localparam logic [PROD_W+1:0] LUM_ROUND  = 34'd32768;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
    logic             meets_aa;
    logic             meets_aaa;
  } ccr_job_t;

  // Restoring long division, used only while building the table.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  function automatic logic [63:0] q30_pow5(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = q30_mul(r, r);
    r4 = q30_mul(r2, r2);
    return q30_mul(r4, r);
  endfunction

  // sRGB transfer curve of one channel code, Q0.16, saturated.
  function automatic logic [LIN_W-1:0] lin_code(input int unsigned code,
                                               input int unsigned bits);
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] v;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    m = (64'd1 << bits) - 64'd1;
    x = 64'(code) & m;
    if (x * 64'd100000 <= 64'd3928 * m) begin
      v = udiv64(64'd6553600 * x + 64'd646 * m, 64'd1292 * m);
    end else begin
      t = udiv64((x * 64'd1000 + 64'd55 * m) << 30, 64'd1055 * m);
      if (t > Q30_ONE) t = Q30_ONE;
      s  = q30_mul(t, t);
      lo = '0;
      hi = Q30_ONE;
      // fifth root of s by bisection
      for (int i = 0; i < 32; i++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo + 64'd1) >> 1);
          if (q30_pow5(mid) <= s) lo = mid;
          else hi = mid - 64'd1;
        end
      end
      v = (q30_mul(s, lo) + 64'd8192) >> 14;
    end
    if (v > 64'd65535) v = 64'd65535;
    return v[LIN_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/color_contrast_ratio_check.sv =====
// Top level of the WCAG contrast ratio checker.
//
// Input channel: in_valid_i/in_ready_o carry two sRGB colors and the
// large_text_i flag. Output channel: out_valid_o/out_ready_i carry the Q5.8
// contrast ratio and the AA and AAA pass flags, one result per transaction,
// in order.
// Throughput: one transaction per cycle while the receiver takes results. The
// path holds four front stages (ROM read, multiply, sum and classify), the
// queue, and thirteen divider stages at one quotient bit each.
// The linearization table is a constant ROM of 2^CHANNEL_BITS entries.
// Reset clears all valid bits and the queue; no result is shown after reset
// until a transaction has passed through.
// When the receiver stalls, the divider holds; the front keeps accepting until
// the four-entry queue and its last stage are full, then in_ready_o drops.
`default_nettype none

module color_contrast_ratio_check #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [CHANNEL_BITS-1:0]       first_red_i,
  input  logic [CHANNEL_BITS-1:0]       first_green_i,
  input  logic [CHANNEL_BITS-1:0]       first_blue_i,
  input  logic [CHANNEL_BITS-1:0]       second_red_i,
  input  logic [CHANNEL_BITS-1:0]       second_green_i,
  input  logic [CHANNEL_BITS-1:0]       second_blue_i,
  input  logic                          large_text_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ccr_pkg::RATIO_W-1:0]   contrast_ratio_o,
  output logic                          meets_aa_o,
  output logic                          meets_aaa_o
);
  import ccr_pkg::*;

  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] chan;
  logic     front_valid, front_ready;
  logic     back_valid, back_ready;
  ccr_job_t front_job, back_job;

  assign chan = {second_blue_i, second_green_i, second_red_i,
                 first_blue_i, first_green_i, first_red_i};

  ccr_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .chan_i       (chan),
    .large_text_i (large_text_i),
    .job_valid_o  (front_valid),
    .job_ready_i  (front_ready),
    .job_o        (front_job)
  );

  ccr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_i       (front_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_o        (back_job)
  );

  ccr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (back_valid),
    .job_ready_o      (back_ready),
    .job_i            (back_job),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .contrast_ratio_o (contrast_ratio_o),
    .meets_aa_o       (meets_aa_o),
    .meets_aaa_o      (meets_aaa_o)
  );

endmodule

`default_nettype wire

// ===== rtl/ccr_front.sv =====
// Front pipeline: channel linearization, luminance and pass classification.
`default_nettype none

module ccr_front #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_ready_o,
  input  logic [ccr_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]     chan_i,
  input  logic                                             large_text_i,
  output logic                                             job_valid_o,
  input  logic                                             job_ready_i,
  output ccr_pkg::ccr_job_t                                job_o
);
  import ccr_pkg::*;

  localparam int NUM_CODES = 2 ** CHANNEL_BITS;

  typedef logic [LIN_W-1:0] rom_t [NUM_CODES];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int c = 0; c < NUM_CODES; c++) begin
      rom[c] = lin_code(c, CHANNEL_BITS);
    end
    return rom;
  endfunction

  localparam rom_t LinRom = build_rom();
  localparam logic [2:0][LIN_W-1:0] WEIGHTS = {W_BLUE, W_GREEN, W_RED};

  logic              adv;
  logic              s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic              large1_q, large2_q, large3_q;
  logic [LIN_W-1:0]  lin_q  [NUM_CH];
  logic [PROD_W-1:0] prod_q [NUM_CH];
  logic [PROD_W+1:0] lum_sum[2];
  logic [LUM_W-1:0]  lum_q  [2];
  logic [NUM_W-1:0]  num_d, den_d;
  logic [CMP_W-1:0]  num_x1, num_x2, den_x3, den_x7, den_x9;
  logic              pass3, pass45, pass7;
  ccr_job_t          job_d, job_q;

  // Stall the whole front while its last stage holds an unqueued transaction.
  assign adv        = !s4_valid_q || job_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      lum_sum[c] = {2'b00, prod_q[3*c]} + {2'b00, prod_q[3*c+1]}
                 + {2'b00, prod_q[3*c+2]} + LUM_ROUND;
    end
  end

  always_comb begin
    if (lum_q[0] > lum_q[1]) begin
      num_d = {1'b0, lum_q[0]} + LUM_OFFSET;
      den_d = {1'b0, lum_q[1]} + LUM_OFFSET;
    end else begin
      num_d = {1'b0, lum_q[1]} + LUM_OFFSET;
      den_d = {1'b0, lum_q[0]} + LUM_OFFSET;
    end
    num_x1 = CMP_W'(num_d);
    num_x2 = CMP_W'({num_d, 1'b0});
    den_x3 = CMP_W'(den_d) + CMP_W'({den_d, 1'b0});
    den_x7 = CMP_W'({den_d, 3'b000}) - CMP_W'(den_d);
    den_x9 = CMP_W'({den_d, 3'b000}) + CMP_W'(den_d);
    pass3  = num_x1 >= den_x3;
    pass45 = num_x2 >= den_x9;
    pass7  = num_x1 >= den_x7;
    job_d.num       = num_d;
    job_d.den       = den_d;
    job_d.meets_aa  = large3_q ? pass3  : pass45;
    job_d.meets_aaa = large3_q ? pass45 : pass7;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NUM_CH; k++) begin
        lin_q[k]  <= LinRom[chan_i[k]];
        prod_q[k] <= PROD_W'(lin_q[k]) * PROD_W'(WEIGHTS[k % 3]);
      end
      for (int c = 0; c < 2; c++) begin
        lum_q[c] <= lum_sum[c][PROD_W-1 -: LUM_W];
      end
      large1_q <= large_text_i;
      large2_q <= large1_q;
      large3_q <= large2_q;
      job_q    <= job_d;
    end
  end

  assign job_valid_o = s4_valid_q;
  assign job_o       = job_q;

endmodule

`default_nettype wire

// ===== rtl/ccr_queue.sv =====
// Short queue that decouples the front pipeline from the divider.
`default_nettype none

module ccr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  ccr_pkg::ccr_job_t push_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output ccr_pkg::ccr_job_t pop_o
);
  import ccr_pkg::*;

  ccr_job_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              push, pop;

  assign push_ready_o = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push && !pop)      count_q <= count_q + (QPTR_W+1)'(1);
      else if (pop && !push) count_q <= count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_i;
  end

endmodule

`default_nettype wire

// ===== rtl/ccr_back.sv =====
// Back end: pipelined restoring divider for the rounded Q5.8 ratio.
`default_nettype none

module ccr_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  output logic                              job_ready_o,
  input  ccr_pkg::ccr_job_t                 job_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ccr_pkg::RATIO_W-1:0]       contrast_ratio_o,
  output logic                              meets_aa_o,
  output logic                              meets_aaa_o
);
  import ccr_pkg::*;

  localparam int STAGES = RATIO_W;

  logic                 adv;
  logic [DVD_W-1:0]     dvd;
  logic [STAGES-1:0]    st_valid_q;
  logic [NUM_W-1:0]     st_rem_q [STAGES];
  logic [NUM_W-1:0]     st_den_q [STAGES];
  logic [RATIO_W-1:0]   st_shf_q [STAGES];
  logic                 st_aa_q  [STAGES];
  logic                 st_aaa_q [STAGES];
  logic [NUM_W-1:0]     in_rem   [STAGES];
  logic [NUM_W-1:0]     in_den   [STAGES];
  logic [RATIO_W-1:0]   in_shf   [STAGES];
  logic                 in_aa    [STAGES];
  logic                 in_aaa   [STAGES];
  logic [NUM_W:0]       trial    [STAGES];
  logic [NUM_W+1:0]     diff     [STAGES];
  logic [NUM_W-1:0]     nxt_rem  [STAGES];
  logic [RATIO_W-1:0]   nxt_shf  [STAGES];

  // Hold every stage while the result register waits on the receiver.
  assign adv         = !st_valid_q[STAGES-1] || out_ready_i;
  assign job_ready_o = adv;

  // num*256 + den/2; the quotient stays below 2^RATIO_W, so the upper half of
  // the dividend is already smaller than den.
  assign dvd = DVD_W'({job_i.num, {FRAC_W{1'b0}}}) + DVD_W'(job_i.den[NUM_W-1:1]);

  always_comb begin
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        in_rem[i] = NUM_W'(dvd[DVD_W-1:RATIO_W]);
        in_shf[i] = dvd[RATIO_W-1:0];
        in_den[i] = job_i.den;
        in_aa[i]  = job_i.meets_aa;
        in_aaa[i] = job_i.meets_aaa;
      end else begin
        in_rem[i] = st_rem_q[i-1];
        in_shf[i] = st_shf_q[i-1];
        in_den[i] = st_den_q[i-1];
        in_aa[i]  = st_aa_q[i-1];
        in_aaa[i] = st_aaa_q[i-1];
      end
      trial[i] = {in_rem[i], in_shf[i][RATIO_W-1]};
      diff[i]  = {1'b0, trial[i]} - {2'b00, in_den[i]};
      if (!diff[i][NUM_W+1]) begin
        nxt_rem[i] = diff[i][NUM_W-1:0];
      end else begin
        nxt_rem[i] = trial[i][NUM_W-1:0];
      end
      nxt_shf[i] = {in_shf[i][RATIO_W-2:0], !diff[i][NUM_W+1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= '0;
    end else if (adv) begin
      st_valid_q <= {st_valid_q[STAGES-2:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < STAGES; i++) begin
        st_rem_q[i] <= nxt_rem[i];
        st_shf_q[i] <= nxt_shf[i];
        st_den_q[i] <= in_den[i];
        st_aa_q[i]  <= in_aa[i];
        st_aaa_q[i] <= in_aaa[i];
      end
    end
  end

  assign out_valid_o      = st_valid_q[STAGES-1];
  assign contrast_ratio_o = st_shf_q[STAGES-1];
  assign meets_aa_o       = st_aa_q[STAGES-1];
  assign meets_aaa_o      = st_aaa_q[STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/ccr_checker.sv =====
// Port-level assertions for the contrast ratio checker, bound to the top level.
`default_nettype none

module ccr_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [ccr_pkg::RATIO_W-1:0]   contrast_ratio_i,
  input  logic                          meets_aa_i,
  input  logic                          meets_aaa_i
);
  import ccr_pkg::*;

  localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(1 << FRAC_W);
  localparam logic [RATIO_W-1:0] RATIO_MAX  = RATIO_W'(21 << FRAC_W);
  localparam logic [RATIO_W-1:0] RATIO_3    = RATIO_W'(3 << FRAC_W);
  localparam logic [RATIO_W-1:0] RATIO_4P5  = RATIO_W'(9 << (FRAC_W - 1));

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(contrast_ratio_i)
      && $stable(meets_aa_i) && $stable(meets_aaa_i))
    else $error("result changed while stalled");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> contrast_ratio_i >= RATIO_ONE && contrast_ratio_i <= RATIO_MAX)
    else $error("contrast ratio out of range");

  a_aaa_implies_aa: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && meets_aaa_i |-> meets_aa_i)
    else $error("AAA pass without AA pass");

  a_aa_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && meets_aa_i |-> contrast_ratio_i >= RATIO_3)
    else $error("AA pass with ratio below 3.0");

  a_aaa_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && meets_aaa_i |-> contrast_ratio_i >= RATIO_4P5)
    else $error("AAA pass with ratio below 4.5");

endmodule

bind color_contrast_ratio_check ccr_checker u_ccr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .contrast_ratio_i (contrast_ratio_o),
  .meets_aa_i       (meets_aa_o),
  .meets_aaa_i      (meets_aaa_o)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the WCAG contrast ratio checker.
`timescale 1ns / 100ps

module tb_top;

  localparam int CH_BITS     = 8;
  localparam int RATIO_BITS  = ccr_pkg::RATIO_W;
  localparam int NUM_RANDOM  = 1930;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [CH_BITS-1:0] first_red;
    logic [CH_BITS-1:0] first_green;
    logic [CH_BITS-1:0] first_blue;
    logic [CH_BITS-1:0] second_red;
    logic [CH_BITS-1:0] second_green;
    logic [CH_BITS-1:0] second_blue;
    logic               large_text;
  } color_pair_t;

  typedef struct {
    logic [RATIO_BITS-1:0] ratio;
    logic                  aa;
    logic                  aaa;
  } verdict_t;

  // Predicts the contrast verdict of each accepted color pair and checks results in order.
  class contrast_scoreboard;
    localparam longint unsigned GAIN_R   = 13933;
    localparam longint unsigned GAIN_G   = 46871;
    localparam longint unsigned GAIN_B   = 4732;
    localparam longint unsigned FLARE    = 3277;
    localparam longint unsigned UNITY_30 = 64'd1 << 30;

    logic [15:0] lin_table[1 << CH_BITS];
    verdict_t    pending_verdicts[$];
    int          mismatches;

    function new();
      mismatches = 0;
      for (int c = 0; c < (1 << CH_BITS); c++) lin_table[c] = srgb_to_linear(c);
    endfunction

    static function longint unsigned pow5_q30(longint unsigned r);
      longint unsigned r2;
      longint unsigned r4;
      r2 = (r * r) >> 30;
      r4 = (r2 * r2) >> 30;
      return (r4 * r) >> 30;
    endfunction

    static function logic [15:0] srgb_to_linear(int unsigned code);
      longint unsigned full;
      longint unsigned x;
      longint unsigned lin;
      longint unsigned base;
      longint unsigned sq;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      full = (64'd1 << CH_BITS) - 1;
      x    = code & full;
      if (x * 100000 <= 3928 * full) begin
        lin = (6553600 * x + 646 * full) / (1292 * full);
      end else begin
        // base^2.4 as base^2 times the fifth root of base^2
        base = ((x * 1000 + 55 * full) << 30) / (1055 * full);
        if (base > UNITY_30) base = UNITY_30;
        sq = (base * base) >> 30;
        lo = 0;
        hi = UNITY_30;
        while (lo < hi) begin
          mid = lo + ((hi - lo + 1) >> 1);
          if (pow5_q30(mid) <= sq) lo = mid;
          else hi = mid - 1;
        end
        lin = (((sq * lo) >> 30) + 8192) >> 14;
      end
      if (lin > 65535) lin = 65535;
      return lin[15:0];
    endfunction

    function longint unsigned luma(logic [CH_BITS-1:0] r, logic [CH_BITS-1:0] g,
                                   logic [CH_BITS-1:0] b);
      return (GAIN_R * lin_table[r] + GAIN_G * lin_table[g] + GAIN_B * lin_table[b]
              + 32768) >> 16;
    endfunction

    function verdict_t predict_verdict(color_pair_t pair);
      longint unsigned l1;
      longint unsigned l2;
      longint unsigned num;
      longint unsigned den;
      longint unsigned q;
      logic            pass3;
      logic            pass45;
      logic            pass7;
      verdict_t        v;
      l1 = luma(pair.first_red, pair.first_green, pair.first_blue);
      l2 = luma(pair.second_red, pair.second_green, pair.second_blue);
      num = ((l1 > l2) ? l1 : l2) + FLARE;
      den = ((l1 > l2) ? l2 : l1) + FLARE;
      q = (num * 256 + den / 2) / den;
      pass3  = (num >= 3 * den);
      pass45 = (2 * num >= 9 * den);
      pass7  = (num >= 7 * den);
      v.ratio = q[RATIO_BITS-1:0];
      v.aa    = pair.large_text ? pass3 : pass45;
      v.aaa   = pair.large_text ? pass45 : pass7;
      return v;
    endfunction

    function void note_colors(color_pair_t pair);
      pending_verdicts.push_back(predict_verdict(pair));
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ratio %0d aa %0b aaa %0b", got.ratio, got.aa, got.aaa);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.ratio !== want.ratio || got.aa !== want.aa || got.aaa !== want.aaa) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected ratio %0d aa %0b aaa %0b, got ratio %0d aa %0b aaa %0b",
                   want.ratio, want.aa, want.aaa, got.ratio, got.aa, got.aaa);
      end
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [CH_BITS-1:0] first_red_i = '0;
  logic [CH_BITS-1:0] first_green_i = '0;
  logic [CH_BITS-1:0] first_blue_i = '0;
  logic [CH_BITS-1:0] second_red_i = '0;
  logic [CH_BITS-1:0] second_green_i = '0;
  logic [CH_BITS-1:0] second_blue_i = '0;
  logic               large_text_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [RATIO_BITS-1:0] contrast_ratio_o;
  logic               meets_aa_o;
  logic               meets_aaa_o;

  logic               hold_off = 1'b0;
  logic [1:0]         stall_mode = 2'd0;
  logic [7:0]         stall_count = '0;
  logic               ready_next;
  int                 cycle_count = 0;

  contrast_scoreboard sb = new();

  color_contrast_ratio_check #(
    .CHANNEL_BITS(CH_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .first_red_i     (first_red_i),
    .first_green_i   (first_green_i),
    .first_blue_i    (first_blue_i),
    .second_red_i    (second_red_i),
    .second_green_i  (second_green_i),
    .second_blue_i   (second_blue_i),
    .large_text_i    (large_text_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .contrast_ratio_o(contrast_ratio_o),
    .meets_aa_o      (meets_aa_o),
    .meets_aaa_o     (meets_aaa_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver stall pattern: pick a new mode each time the 8-bit stall counter wraps to zero.
  always @(posedge clk_i) begin
    stall_count <= stall_count + 8'd1;
    if (stall_count == 8'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: ready_next = 1'b1;
      2'd1: ready_next = ($urandom_range(0, 1) == 0);
      2'd2: ready_next = (stall_count[1:0] == 2'd0);
      default: ready_next = (stall_count[3:0] < 4'd11);
    endcase
    out_ready_i <= ready_next && !hold_off;
  end

  // Long receiver hold-offs so the queue fills and the input stalls.
  initial begin
    @(posedge rst_ni);
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b0;
    repeat (1500) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_verdict('{ratio: contrast_ratio_o, aa: meets_aa_o, aaa: meets_aaa_o});
  end

  task automatic send_pair(input color_pair_t pair);
    in_valid_i     <= 1'b1;
    first_red_i    <= pair.first_red;
    first_green_i  <= pair.first_green;
    first_blue_i   <= pair.first_blue;
    second_red_i   <= pair.second_red;
    second_green_i <= pair.second_green;
    second_blue_i  <= pair.second_blue;
    large_text_i   <= pair.large_text;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_colors(pair);
  endtask

  task automatic idle_input(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic color_pair_t make_pair(int fr, int fg, int fb, int sr, int sg, int sbl,
                                            int lt);
    color_pair_t p;
    p.first_red    = fr[CH_BITS-1:0];
    p.first_green  = fg[CH_BITS-1:0];
    p.first_blue   = fb[CH_BITS-1:0];
    p.second_red   = sr[CH_BITS-1:0];
    p.second_green = sg[CH_BITS-1:0];
    p.second_blue  = sbl[CH_BITS-1:0];
    p.large_text   = lt[0];
    return p;
  endfunction

  function automatic color_pair_t random_pair();
    color_pair_t p;
    int          kind;
    int          hi;
    kind = $urandom_range(0, 9);
    p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (kind == 0) begin
      // same color twice: equal luminance
      p.second_red   = p.first_red;
      p.second_green = p.first_green;
      p.second_blue  = p.first_blue;
    end else if (kind == 1) begin
      // dark codes around the knee of the transfer curve
      hi = 24;
      p = make_pair($urandom_range(0, hi), $urandom_range(0, hi), $urandom_range(0, hi),
                    $urandom_range(0, hi), $urandom_range(0, hi), $urandom_range(0, hi),
                    $urandom);
    end else if (kind == 2) begin
      p = make_pair($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                    $urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                    $urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255, $urandom);
    end else if (kind == 3) begin
      // gray pairs land near the pass thresholds often
      hi = $urandom_range(0, 255);
      p = make_pair(hi, hi, hi, $urandom_range(0, 255), 0, 0, $urandom);
      p.second_green = p.second_red;
      p.second_blue  = p.second_red;
    end
    return p;
  endfunction

  initial begin
    color_pair_t directed[$];
    int          burst;
    int          sent;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(make_pair(0, 0, 0, 255, 255, 255, 0));
    directed.push_back(make_pair(255, 255, 255, 0, 0, 0, 1));
    directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_pair(255, 255, 255, 255, 255, 255, 1));
    directed.push_back(make_pair(118, 118, 118, 255, 255, 255, 0));
    directed.push_back(make_pair(118, 118, 118, 255, 255, 255, 1));
    directed.push_back(make_pair(148, 148, 148, 255, 255, 255, 0));
    directed.push_back(make_pair(148, 148, 148, 255, 255, 255, 1));
    directed.push_back(make_pair(89, 89, 89, 255, 255, 255, 0));
    directed.push_back(make_pair(89, 89, 89, 255, 255, 255, 1));
    directed.push_back(make_pair(10, 10, 10, 11, 11, 11, 0));
    directed.push_back(make_pair(1, 0, 0, 0, 0, 1, 1));
    directed.push_back(make_pair(255, 0, 0, 0, 255, 0, 0));
    directed.push_back(make_pair(0, 0, 255, 255, 255, 0, 1));
    directed.push_back(make_pair(128, 64, 32, 128, 64, 32, 1));
    directed.push_back(make_pair(170, 85, 204, 85, 170, 51, 0));
    directed.push_back(make_pair(254, 254, 254, 1, 1, 1, 0));
    directed.push_back(make_pair(0, 255, 0, 0, 0, 0, 1));
    directed.push_back(make_pair(0, 0, 0, 255, 0, 0, 0));
    directed.push_back(make_pair(0, 0, 0, 0, 0, 255, 1));
    foreach (directed[i]) send_pair(directed[i]);

    sent = 0;
    while (sent < NUM_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < NUM_RANDOM; k++) begin
        send_pair(random_pair());
        sent++;
      end
      if ($urandom_range(0, 9) >= 3) idle_input($urandom_range(1, 6));
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
